// ===== hdl/rdcl_pkg.sv =====
package rdcl_pkg;

	// Widths fixed by the channel format
	localparam int unsigned FIELD_BITS = 16;
	localparam int unsigned LEN_BITS   = 11;
	localparam logic [LEN_BITS-1:0] CHAIN_MAX = 11'h7FF;

	typedef struct packed {
		logic [FIELD_BITS-1:0] left_x;
		logic [FIELD_BITS-1:0] bottom_y;
		logic [FIELD_BITS-1:0] right_x;
		logic [FIELD_BITS-1:0] top_y;
		logic                  last_rect;
	} rdcl_req_t;

	typedef struct packed {
		logic [LEN_BITS-1:0] chain_length;
		logic                overflow;
	} rdcl_rsp_t;

endpackage

// ===== hdl/rdcl_ram.sv =====
module rdcl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/rect_dominance_chain_length.sv =====
// Longest chain of rectangles under strict 2-D dominance.
//
// Requests: one rectangle per request, taken at a rising edge with start high
// and busy low. Rectangles load at one per cycle into the rectangle memory.
// The request with last_rect set closes the set; busy then rises and the
// sweep runs. Rectangles beyond MAX_RECTS are dropped and flag overflow.
// Sweep: for each of the n stored rectangles, in order of left edge (ties in
// load order), one pass over the rectangle memory picks the next rectangle
// and a second pass over the rectangle and length memories finds its best
// predecessor. Each memory has one read port, so a pass reads the stored
// rectangles one by one; the new length is then written to the length memory.
// Result: valid is high for one cycle with chain_length and overflow,
// registered from the done state after the sweep ends; the receiver cannot
// stall, so the result is simply presented once. busy falls in the same cycle
// and the next request starts a new set.
// Reset clears the count, the overflow flag and the sequencer; memory
// contents stay undefined and are only read where written.
module rect_dominance_chain_length
	import rdcl_pkg::*;
#(
	parameter int unsigned MAX_RECTS  = 1024,
	parameter int unsigned COORD_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  rdcl_req_t req,
	output logic      valid,
	output rdcl_rsp_t rsp
);

	localparam int unsigned CW = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
	localparam int unsigned AW = $clog2(MAX_RECTS);
	localparam int unsigned NW = $clog2(MAX_RECTS + 1);
	localparam int unsigned LW = NW;
	localparam int unsigned SW = (LW > LEN_BITS) ? LW : LEN_BITS;
	localparam int unsigned RW = 4 * CW;

	typedef enum logic [4:0] {
		ST_LOAD = 5'b00001,
		ST_SEL  = 5'b00010,
		ST_DOM  = 5'b00100,
		ST_WR   = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t          state_q;
	logic [NW-1:0]   count_q;
	logic            dropped_q;
	logic [NW-1:0]   scan_q;
	logic [NW-1:0]   pass_q;
	logic            v_s1;
	logic [AW-1:0]   j_s1;
	logic            found_q;
	logic            first_q;
	logic [CW-1:0]   last_x_q;
	logic [AW-1:0]   last_idx_q;
	logic [CW-1:0]   cur_x0_q;
	logic [CW-1:0]   cur_y0_q;
	logic [AW-1:0]   cur_idx_q;
	logic [LW-1:0]   acc_q;
	logic [LW-1:0]   best_q;
	logic            res_v_q;
	rdcl_rsp_t       res_q;

	logic            accept;
	logic            store_we;
	logic [RW-1:0]   store_wdata;
	logic [RW-1:0]   rect_rd;
	logic [LW-1:0]   len_rd;
	logic            len_we;
	logic [LW-1:0]   len_new;
	logic            issue;
	logic            scan_end;
	logic [NW-1:0]   pass_nxt;
	logic [CW-1:0]   x0_j, y0_j, x1_j, y1_j;
	logic            after_last, before_cur, take;
	logic            precedes, dominated;
	logic [SW-1:0]   best_ext;

	assign accept      = start && (state_q == ST_LOAD);
	assign store_we    = accept && (count_q < NW'(MAX_RECTS));
	assign store_wdata = {req.left_x[CW-1:0], req.bottom_y[CW-1:0],
	                      req.right_x[CW-1:0], req.top_y[CW-1:0]};
	assign issue       = ((state_q == ST_SEL) || (state_q == ST_DOM)) && (scan_q != count_q);
	assign scan_end    = (scan_q == count_q) && !v_s1;
	assign pass_nxt    = pass_q + NW'(1);
	assign len_we      = (state_q == ST_WR);
	assign len_new     = acc_q + LW'(1);
	assign {x0_j, y0_j, x1_j, y1_j} = rect_rd;

	rdcl_ram #(.WIDTH(RW), .DEPTH(MAX_RECTS)) u_rect_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[AW-1:0]),
		.wdata (store_wdata),
		.raddr (scan_q[AW-1:0]),
		.rdata (rect_rd)
	);

	rdcl_ram #(.WIDTH(LW), .DEPTH(MAX_RECTS)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (cur_idx_q),
		.wdata (len_new),
		.raddr (scan_q[AW-1:0]),
		.rdata (len_rd)
	);

	// Select: next rectangle after the last one in (left edge, index) order; also the dominance test
	always_comb begin
		after_last = first_q || (x0_j > last_x_q) || ((x0_j == last_x_q) && (j_s1 > last_idx_q));
		before_cur = !found_q || (x0_j < cur_x0_q) || ((x0_j == cur_x0_q) && (j_s1 < cur_idx_q));
		take       = v_s1 && (state_q == ST_SEL) && after_last && before_cur;
		precedes   = (x0_j < cur_x0_q) || ((x0_j == cur_x0_q) && (j_s1 < cur_idx_q));
		dominated  = v_s1 && (state_q == ST_DOM) && precedes &&
		             (x1_j < cur_x0_q) && (y1_j < cur_y0_q);
	end

	// Sequence loading, selection and predecessor passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
			scan_q    <= '0;
			pass_q    <= '0;
			v_s1      <= 1'b0;
			found_q   <= 1'b0;
			first_q   <= 1'b1;
			acc_q     <= '0;
			best_q    <= '0;
			res_v_q   <= 1'b0;
		end else begin
			v_s1    <= issue;
			res_v_q <= 1'b0;
			if (issue) begin
				scan_q <= scan_q + NW'(1);
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (store_we) begin
							count_q <= count_q + NW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (req.last_rect) begin
							state_q <= ST_SEL;
							scan_q  <= '0;
							pass_q  <= '0;
							found_q <= 1'b0;
							first_q <= 1'b1;
							best_q  <= '0;
						end
					end
				end
				ST_SEL: begin
					if (take) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_DOM;
						scan_q  <= '0;
						acc_q   <= '0;
						first_q <= 1'b0;
					end
				end
				ST_DOM: begin
					if (dominated && (len_rd > acc_q)) begin
						acc_q <= len_rd;
					end
					if (scan_end) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (len_new > best_q) begin
						best_q <= len_new;
					end
					pass_q  <= pass_nxt;
					scan_q  <= '0;
					found_q <= 1'b0;
					state_q <= (pass_nxt == count_q) ? ST_DONE : ST_SEL;
				end
				ST_DONE: begin
					res_v_q   <= 1'b1;
					count_q   <= '0;
					dropped_q <= 1'b0;
					state_q   <= ST_LOAD;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Hold payload of the candidate, the last pick and the result
	assign best_ext = SW'(best_q);
	always_ff @(posedge clk) begin
		if (take) begin
			cur_x0_q  <= x0_j;
			cur_y0_q  <= y0_j;
			cur_idx_q <= j_s1;
		end
		if ((state_q == ST_SEL) && scan_end) begin
			last_x_q   <= cur_x0_q;
			last_idx_q <= cur_idx_q;
		end
		j_s1 <= scan_q[AW-1:0];
		if (state_q == ST_DONE) begin
			res_q.chain_length <= (best_ext > SW'(CHAIN_MAX)) ? CHAIN_MAX
			                      : best_ext[LEN_BITS-1:0];
			res_q.overflow     <= dropped_q;
		end
	end

	assign busy  = (state_q != ST_LOAD);
	assign valid = res_v_q;
	assign rsp   = res_q;

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (count_q == '0) && !busy)
		else $error("set not cleared after result");
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		len_we |-> found_q && (len_new != '0))
		else $error("length write without a selected rectangle");
	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (pass_q < count_q) || (state_q == ST_DONE))
		else $error("pass count past set size");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= count_q)
		else $error("scan past set size");

endmodule
